@@ sv/c2mf_pkg.sv @@
// ----------------------------------------------------------------------------
// c2mf_pkg
// Shared widths, field offsets, codes and types of the 3x3 multi-filter core.
// ----------------------------------------------------------------------------
package c2mf_pkg;

  localparam int MAX_WIDTH_DEF   = 256;
  localparam int NUM_FILTERS_DEF = 8;
  localparam int MAX_FILTERS     = 8;
  localparam int KERNEL_H        = 3;
  localparam int KERNEL_W        = 3;
  localparam int TAPS            = KERNEL_H * KERNEL_W;
  localparam int MAX_HEIGHT      = 4096;

  localparam int PIX_W  = 16;
  localparam int WGT_W  = 16;
  localparam int PROD_W = PIX_W + WGT_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int SUM_W  = 36;

  localparam int FIDX_W    = 3;
  localparam int TAP_W     = 4;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 8;

  // input beat layout
  localparam int FIDX_OFF   = 0;
  localparam int TAP_OFF    = FIDX_OFF + FIDX_W;
  localparam int WGT_OFF    = TAP_OFF + TAP_W;
  localparam int PIX_OFF    = WGT_OFF + WGT_W;
  localparam int IN_USED_W  = PIX_OFF + PIX_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // result beat layout
  localparam int ROW_OFF     = 0;
  localparam int COL_OFF     = ROW_OFF + ROW_W;
  localparam int SUM_OFF     = COL_OFF + OUT_COL_W;
  localparam int OUT_USED_W  = SUM_OFF + MAX_FILTERS * SUM_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_WIDTH_W  = 9;
  localparam int CFG_HEIGHT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [WGT_W-1:0]  wgt_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PSUM_W-1:0] psum_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } pos_t;

endpackage

@@ sv/conv2d_multi_filter_stream_core.sv @@
// ----------------------------------------------------------------------------
// conv2d_multi_filter_stream_core
// Streaming 3x3 valid convolution of a raster-order image with up to eight
// filters. One input beat per clock while in_tready is high: a weight beat
// (tuser low) writes one tap of one filter, a pixel beat (tuser high) shifts
// the window and, once it sits on a valid position, yields one result beat via
// stage 1, window, products, row sums and output register, holding the filter
// sums, the output row and column and tlast on the image's final position. The
// two line stores share one MAX_WIDTH-deep memory of upper/middle pairs, read
// at the pixel's column on acceptance and written back from stage 1; a column
// is revisited only after a whole row, so no forwarding is needed. The datapath
// is a pipeline of window, 72 parallel multipliers and a two-level adder tree,
// so input is taken every cycle unless a result sits in the last stage and the
// output stalls. Weight writes travel a matching two-stage delay, so every pixel
// sees exactly the weights loaded before it. Line stores need no clearing pass;
// a width or height register write restarts the image at row 0, column 0.
// ----------------------------------------------------------------------------
module conv2d_multi_filter_stream_core #(
  parameter int MAX_WIDTH   = c2mf_pkg::MAX_WIDTH_DEF,
  parameter int NUM_FILTERS = c2mf_pkg::NUM_FILTERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // filter_index, tap_index, weight_value, pixel_value
  input  logic [c2mf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_row, out_col, sum_f0 .. sum_f7
  output logic [c2mf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [c2mf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [c2mf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import c2mf_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int W_RST  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int LINE_W = 2 * PIX_W;

  // input fields
  logic [FIDX_W-1:0] in_fidx;
  logic [TAP_W-1:0]  in_tap;
  wgt_t              in_wgt;
  pix_t              in_pix;

  assign in_fidx = in_tdata[FIDX_OFF +: FIDX_W];
  assign in_tap  = in_tdata[TAP_OFF +: TAP_W];
  assign in_wgt  = in_tdata[WGT_OFF +: WGT_W];
  assign in_pix  = in_tdata[PIX_OFF +: PIX_W];

  // handshakes
  logic out_ld, adv, in_acc, pix_acc, wt_acc, cfg_acc, cfg_restart;
  logic s4_v_r, out_v_r;

  assign out_ld      = !out_v_r || out_tready;
  assign adv         = out_ld || !s4_v_r;
  assign in_tready   = adv;
  assign cfg_ready   = 1'b1;
  assign in_acc      = in_tvalid && in_tready;
  assign pix_acc     = in_acc && (in_tuser == KIND_PIXEL);
  assign wt_acc      = in_acc && (in_tuser == KIND_WEIGHT);
  assign cfg_acc     = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_acc &&
                       (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // image geometry, held as last column / last row after clamping
  logic [CW-1:0]           w_last_r, w_last_nxt;
  logic [ROW_W-1:0]        h_last_r, h_last_nxt;
  logic [CFG_WIDTH_W-1:0]  cfg_w;
  logic [CFG_HEIGHT_W-1:0] cfg_h;

  assign cfg_w = cfg_data[CFG_WIDTH_W-1:0];
  assign cfg_h = cfg_data[CFG_HEIGHT_W-1:0];

  always_comb begin
    if (cfg_w < CFG_WIDTH_W'(KERNEL_W)) begin
      w_last_nxt = CW'(KERNEL_W - 1);
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      w_last_nxt = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_nxt = CW'(cfg_w - CFG_WIDTH_W'(1));
    end
    if (cfg_h < CFG_HEIGHT_W'(KERNEL_H)) begin
      h_last_nxt = ROW_W'(KERNEL_H - 1);
    end else if (cfg_h > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      h_last_nxt = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last_nxt = ROW_W'(cfg_h - CFG_HEIGHT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(W_RST - 1);
      h_last_r <= ROW_W'(256 - 1);
    end else if (cfg_acc) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        w_last_r <= w_last_nxt;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        h_last_r <= h_last_nxt;
      end
    end
  end

  // raster position
  logic [CW-1:0]    col_r, col_nxt, col_m2;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             col_end, row_end, emit;
  pos_t             pos_in;

  assign col_end = (col_r == w_last_r);
  assign row_end = (row_r == h_last_r);
  assign emit    = (row_r >= ROW_W'(KERNEL_H - 1)) && (col_r >= CW'(KERNEL_W - 1));
  assign col_m2  = col_r - CW'(KERNEL_W - 1);

  assign pos_in.row  = row_r - ROW_W'(KERNEL_H - 1);
  assign pos_in.col  = OUT_COL_W'(col_m2);
  assign pos_in.last = row_end && col_end;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (pix_acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: pixel beat waits for its line-store read
  logic          s1_v_r, s1_emit_r;
  logic [CW-1:0] s1_col_r;
  pix_t          s1_pix_r;
  pos_t          s1_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_emit_r <= emit;
      s1_col_r  <= col_r;
      s1_pix_r  <= in_pix;
      s1_pos_r  <= pos_in;
    end
  end

  // line stores: upper in the high half, middle in the low half
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      rd_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      line_mem[s1_col_r] <= {rd_r[PIX_W-1:0], s1_pix_r};
    end
  end

  // stage 2: window
  pix_t win_r [TAPS];
  logic s2_v_r;
  pos_t s2_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        win_r[k] <= '0;
      end
    end else if (adv && s1_v_r) begin
      for (int r = 0; r < KERNEL_H; r++) begin
        for (int c = 0; c < KERNEL_W - 1; c++) begin
          win_r[r*KERNEL_W + c] <= win_r[r*KERNEL_W + c + 1];
        end
      end
      win_r[KERNEL_W - 1]     <= rd_r[LINE_W-1:PIX_W];
      win_r[2*KERNEL_W - 1]   <= rd_r[PIX_W-1:0];
      win_r[KERNEL_H*KERNEL_W - 1] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pos_r <= s1_pos_r;
    end
  end

  // weight writes pass w1 and w2 ahead of the table, matching pixel stage 1 and window
  logic              w1_v_r, w2_v_r;
  logic [FIDX_W-1:0] w1_f_r, w2_f_r;
  logic [TAP_W-1:0]  w1_k_r, w2_k_r;
  wgt_t              w1_val_r, w2_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_v_r <= 1'b0;
      w2_v_r <= 1'b0;
    end else if (adv) begin
      w1_v_r <= wt_acc;
      w2_v_r <= w1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_f_r   <= in_fidx;
      w1_k_r   <= in_tap;
      w1_val_r <= in_wgt;
      w2_f_r   <= w1_f_r;
      w2_k_r   <= w1_k_r;
      w2_val_r <= w1_val_r;
    end
  end

  wgt_t wt_r [NUM_FILTERS][TAPS];

  for (genvar gf = 0; gf < NUM_FILTERS; gf++) begin : g_wf
    for (genvar gk = 0; gk < TAPS; gk++) begin : g_wk
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          wt_r[gf][gk] <= '0;
        end else if (adv && w2_v_r && w2_f_r == FIDX_W'(gf) && w2_k_r == TAP_W'(gk)) begin
          wt_r[gf][gk] <= w2_val_r;
        end
      end
    end
  end

  // stage 3 products, stage 4 row sums, output register final sums
  prod_t prod_r [NUM_FILTERS][TAPS];
  psum_t psum_r [NUM_FILTERS][KERNEL_H];
  sum_t  out_sum_r [NUM_FILTERS];
  logic  s3_v_r;
  pos_t  s3_pos_r, s4_pos_r, out_pos_r;

  for (genvar gf = 0; gf < NUM_FILTERS; gf++) begin : g_mac
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < TAPS; k++) begin
          prod_r[gf][k] <= win_r[k] * wt_r[gf][k];
        end
        for (int r = 0; r < KERNEL_H; r++) begin
          psum_r[gf][r] <= PSUM_W'(prod_r[gf][r*KERNEL_W])
                         + PSUM_W'(prod_r[gf][r*KERNEL_W + 1])
                         + PSUM_W'(prod_r[gf][r*KERNEL_W + 2]);
        end
      end
      if (adv && out_ld) begin
        out_sum_r[gf] <= SUM_W'(psum_r[gf][0]) + SUM_W'(psum_r[gf][1])
                       + SUM_W'(psum_r[gf][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        s3_v_r <= s2_v_r;
        s4_v_r <= s3_v_r;
      end
      if (out_ld) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pos_r <= s2_pos_r;
      s4_pos_r <= s3_pos_r;
    end
    if (out_ld) begin
      out_pos_r <= s4_pos_r;
    end
  end

  // result beat
  assign out_tvalid = out_v_r;
  assign out_tlast  = out_pos_r.last;
  assign out_tdata[ROW_OFF +: ROW_W]     = out_pos_r.row;
  assign out_tdata[COL_OFF +: OUT_COL_W] = out_pos_r.col;

  for (genvar gf = 0; gf < MAX_FILTERS; gf++) begin : g_pack
    if (gf < NUM_FILTERS) begin : g_used
      assign out_tdata[SUM_OFF + gf*SUM_W +: SUM_W] = out_sum_r[gf];
    end else begin : g_unused
      assign out_tdata[SUM_OFF + gf*SUM_W +: SUM_W] = '0;
    end
  end

  if (OUT_TDATA_W > OUT_USED_W) begin : g_pad
    assign out_tdata[OUT_TDATA_W-1:OUT_USED_W] = '0;
  end

endmodule

@@ sv/c2mf_checker.sv @@
// ----------------------------------------------------------------------------
// c2mf_checker
// Port-level checks of the multi-filter convolution core, bound to its top.
// ----------------------------------------------------------------------------
module c2mf_checker #(
  parameter int NUM_FILTERS = c2mf_pkg::NUM_FILTERS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [c2mf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);
  import c2mf_pkg::*;

  function automatic logic [OUT_TDATA_W-1:0] unused_mask();
    logic [OUT_TDATA_W-1:0] m;
    m = '0;
    for (int f = NUM_FILTERS; f < MAX_FILTERS; f++) begin
      m[SUM_OFF + f*SUM_W +: SUM_W] = '1;
    end
    return m;
  endfunction

  localparam logic [OUT_TDATA_W-1:0] UNUSED_MASK = unused_mask();

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // output register cleared by reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // input only backs up behind a stalled result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with free output");

  // sums of absent filters read as zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata & UNUSED_MASK) == '0)
    else $error("unused filter sum not zero");

endmodule

bind conv2d_multi_filter_stream_core c2mf_checker #(
  .NUM_FILTERS(NUM_FILTERS)
) u_c2mf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

@@ tb/conv2d_filter_bank_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_filter_bank_checker
// Watches the pixel/weight, register and result channels of the 3x3
// multi-filter core. It keeps its own line stores, window, weight table and
// raster position, predicts the eight filter sums of every valid window, and
// compares each result beat field by field with the oldest predicted window.
// ----------------------------------------------------------------------------
module conv2d_filter_bank_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [c2mf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [c2mf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [c2mf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [c2mf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               error_count,
  output int                               pending_count,
  output int                               result_count
);
  import c2mf_pkg::*;

  typedef struct packed {
    pos_t                              pos;
    logic [MAX_FILTERS-1:0][SUM_W-1:0] sums;
  } window_sums_t;

  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;
  pix_t         upper_mem  [MAX_WIDTH_DEF];
  pix_t         middle_mem [MAX_WIDTH_DEF];
  pix_t         window     [TAPS];
  wgt_t         coef       [MAX_FILTERS][TAPS];
  int unsigned  row_idx;
  int unsigned  col_idx;
  window_sums_t sums_due [$];
  int           errors = 0;
  int           results = 0;

  task automatic check_field(input string name, input logic [SUM_W-1:0] want_v,
                             input logic [SUM_W-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : track
    int unsigned       w;
    int unsigned       h;
    int unsigned       c;
    int unsigned       r;
    longint            acc;
    window_sums_t      want;
    logic [FIDX_W-1:0] fidx;
    logic [TAP_W-1:0]  tap;

    if (!rst_n) begin
      // reset frame is 256x256
      width_reg  = CFG_WIDTH_W'(MAX_WIDTH_DEF);
      height_reg = 13'd256;
      row_idx    = 0;
      col_idx    = 0;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        upper_mem[i]  = '0;
        middle_mem[i] = '0;
      end
      for (int k = 0; k < TAPS; k++) begin
        window[k] = '0;
        for (int f = 0; f < MAX_FILTERS; f++) coef[f][k] = '0;
      end
      sums_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        // only the two real registers restart the frame
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_reg = cfg_data[CFG_WIDTH_W-1:0];
          row_idx   = 0;
          col_idx   = 0;
        end else if (cfg_index == REG_IMAGE_HEIGHT) begin
          height_reg = cfg_data[CFG_HEIGHT_W-1:0];
          row_idx    = 0;
          col_idx    = 0;
        end
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_WEIGHT) begin
          fidx = in_tdata[FIDX_OFF +: FIDX_W];
          tap  = in_tdata[TAP_OFF +: TAP_W];
          if (fidx < NUM_FILTERS_DEF && tap < TAPS) begin
            coef[fidx][tap] = in_tdata[WGT_OFF +: WGT_W];
          end
        end else begin
          w = width_reg;
          if (w < KERNEL_W) w = KERNEL_W;
          else if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
          h = height_reg;
          if (h < KERNEL_H) h = KERNEL_H;
          else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
          c = (col_idx >= w) ? 0 : col_idx;
          r = (row_idx >= h) ? 0 : row_idx;

          for (int k = 0; k < KERNEL_H; k++) begin
            window[k*KERNEL_W]     = window[k*KERNEL_W + 1];
            window[k*KERNEL_W + 1] = window[k*KERNEL_W + 2];
          end
          window[KERNEL_W-1]   = upper_mem[c];
          window[2*KERNEL_W-1] = middle_mem[c];
          window[TAPS-1]       = in_tdata[PIX_OFF +: PIX_W];
          upper_mem[c]  = middle_mem[c];
          middle_mem[c] = in_tdata[PIX_OFF +: PIX_W];

          if (r >= KERNEL_H - 1 && c >= KERNEL_W - 1) begin
            want.pos.row  = ROW_W'(r - (KERNEL_H - 1));
            want.pos.col  = OUT_COL_W'(c - (KERNEL_W - 1));
            want.pos.last = (r == h - 1) && (c == w - 1);
            for (int f = 0; f < MAX_FILTERS; f++) begin
              acc = 0;
              if (f < NUM_FILTERS_DEF) begin
                for (int k = 0; k < TAPS; k++) begin
                  acc += longint'(window[k]) * longint'(coef[f][k]);
                end
              end
              want.sums[f] = acc[SUM_W-1:0];
            end
            sums_due = {sums_due, want};
          end

          if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
          end else begin
            c = c + 1;
          end
          col_idx = c;
          row_idx = r;
        end
      end

      if (out_tvalid && out_tready) begin
        results++;
        if (sums_due.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing pending, expected none, actual row %0d col %0d",
                   $time, out_tdata[ROW_OFF +: ROW_W], out_tdata[COL_OFF +: OUT_COL_W]);
        end else begin
          want = sums_due.pop_front();
          check_field("out_row", SUM_W'(want.pos.row), SUM_W'(out_tdata[ROW_OFF +: ROW_W]));
          check_field("out_col", SUM_W'(want.pos.col), SUM_W'(out_tdata[COL_OFF +: OUT_COL_W]));
          for (int f = 0; f < MAX_FILTERS; f++) begin
            check_field($sformatf("sum_f%0d", f), want.sums[f],
                        out_tdata[SUM_OFF + f*SUM_W +: SUM_W]);
          end
          check_field("last_of_image", SUM_W'(want.pos.last), SUM_W'(out_tlast));
        end
      end
    end

    error_count   <= errors;
    pending_count <= sums_due.size();
    result_count  <= results;
  end

endmodule

@@ tb/conv2d_multi_filter_stream_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_multi_filter_stream_core_tb
// Drives weight and pixel beats and frame-size writes into the 3x3
// multi-filter core with random gaps and output stalls: a directed 3x3 pass,
// one full-width frame and the top rows of a full-height frame with clamped
// sizes, then random small frames, whole and cut short, with weight reloads
// mixed in.
// ----------------------------------------------------------------------------
module conv2d_multi_filter_stream_core_tb;
  import c2mf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam pix_t VAL_LO       = 16'sh8000;
  localparam pix_t VAL_HI       = 16'sh7fff;
  localparam int   RANDOM_ITEMS = 280;
  localparam int   TALL_ROWS    = 20;
  localparam int   DRAIN_CYCLES = 10;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     error_count;
  int                     pending_count;
  int                     result_count;

  int pixels_sent = 0;
  int weights_sent = 0;
  int reg_writes = 0;
  bit burst_mode = 1'b0;
  int stall_left = 0;
  bit quiet_rx = 1'b0;
  int rx_cycle = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  conv2d_multi_filter_stream_core dut (.*);

  conv2d_filter_bank_checker u_checker (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return VAL_LO;
    if (r == 1) return VAL_HI;
    return 16'($urandom);
  endfunction

  // result side: random stalls, with quiet stretches
  always @(posedge clk) begin
    if (rx_cycle % 250 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
    rx_cycle++;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!quiet_rx) stall_left = pick_gap();
    end
  end

  task automatic send_beat(input logic kind, input logic [FIDX_W-1:0] fidx,
                           input logic [TAP_W-1:0] tap, input wgt_t wgt, input pix_t pix);
    int                    gap;
    logic [IN_TDATA_W-1:0] beat;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat = '0;
    beat[FIDX_OFF +: FIDX_W] = fidx;
    beat[TAP_OFF +: TAP_W]   = tap;
    beat[WGT_OFF +: WGT_W]   = wgt;
    beat[PIX_OFF +: PIX_W]   = pix;
    in_tdata  <= beat;
    in_tuser  <= kind;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // pixel field of a weight beat is don't-care, so fill it randomly
  task automatic load_weight(input logic [FIDX_W-1:0] fidx, input logic [TAP_W-1:0] tap,
                             input wgt_t wgt);
    send_beat(KIND_WEIGHT, fidx, tap, wgt, pix_t'($urandom));
    if (tap < TAPS) weights_sent++;
  endtask

  task automatic push_pixel(input pix_t pix);
    send_beat(KIND_PIXEL, FIDX_W'($urandom), TAP_W'($urandom), wgt_t'($urandom), pix);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // weight beats leave nothing to wait on, so cover the pipeline depth too
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic stream_pixels(input int count, input int weight_pct, input bit spare_mid);
    int tap;
    for (int i = 0; i < count; i++) begin
      // spare register indexes must not restart the frame
      if (spare_mid && i == count / 2) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 99) < weight_pct) begin
        tap = ($urandom_range(0, 6) == 0) ? $urandom_range(TAPS, 15) : $urandom_range(0, TAPS-1);
        load_weight(FIDX_W'($urandom), TAP_W'(tap), pick_value());
      end
      push_pixel(pick_value());
    end
  endtask

  initial begin : stimulus
    int w_data;
    int h_data;
    int cur_w;
    int cur_h;
    int total;
    int start_items;
    int mode;
    bit first;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_PIXEL;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame: one window per frame
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    load_weight(3'd0, 4'd0, VAL_LO);
    load_weight(3'd1, 4'd4, VAL_HI);
    load_weight(3'd7, 4'd8, VAL_LO);
    load_weight(3'd7, 4'd0, VAL_HI);
    load_weight(3'd2, 4'd9, VAL_HI);
    load_weight(3'd5, 4'd15, VAL_LO);
    for (int i = 0; i < TAPS; i++) push_pixel(i[0] ? VAL_HI : VAL_LO);
    // next frame runs on without a write, weight changes mid-frame
    for (int i = 0; i < TAPS; i++) begin
      if (i == 4) load_weight(3'd0, 4'd0, VAL_HI);
      push_pixel(i[0] ? VAL_LO : VAL_HI);
    end

    // width field 511 clamps to the full line, height 0 clamps to 3
    write_reg(REG_IMAGE_WIDTH, 13'h1fff);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    stream_pixels(MAX_WIDTH_DEF * KERNEL_H, 2, 1'b0);

    // narrowest frame, height field clamps to 4096 rows, only the top rows sent
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'h1fff);
    stream_pixels(KERNEL_W * TALL_ROWS, 1, 1'b0);

    start_items = pixels_sent + weights_sent;
    first = 1'b1;
    cur_w = KERNEL_W;
    cur_h = MAX_HEIGHT;
    while (pixels_sent + weights_sent - start_items < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      w_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      mode = first ? 2 : $urandom_range(0, 3);
      first = 1'b0;
      // upper bits of a width write lie outside the register
      if (mode != 1) write_reg(REG_IMAGE_WIDTH, {4'($urandom), 9'(w_data)});
      if (mode != 0) write_reg(REG_IMAGE_HEIGHT, 13'(h_data));
      if (mode == 3) write_reg(REG_IMAGE_WIDTH, {4'($urandom), 9'(w_data)});
      if (mode != 1) cur_w = (w_data < KERNEL_W) ? KERNEL_W : w_data;
      if (mode != 0) cur_h = (h_data < KERNEL_H) ? KERNEL_H : h_data;
      total = $urandom_range(1, 3) * cur_w * cur_h;
      // some phases break off mid-frame
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total - 1);
      stream_pixels(total, 8, $urandom_range(0, 5) == 0);
    end
    burst_mode = 1'b0;

    wait_idle();
    $display("run covered %0d pixel beats and %0d weight loads over %0d register writes",
             pixels_sent, weights_sent, reg_writes);
    $display("frames from 3x3 up to 256x3 plus the top rows of 3x4096, %0d results checked",
             result_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(100_000_000);
    $display("timeout with %0d results still pending", pending_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
